@@ rtl/core/bpc_pkg.sv @@
// Shared types and codes for the bus transaction phase checker.
// Holds the event and phase enums, packet type codes and beat structs; no dependencies.
package bpc_pkg;

  typedef enum logic [2:0] {
    CMD_BEGIN       = 3'd0,
    CMD_FINISH      = 3'd1,
    CMD_ACK         = 3'd2,
    CMD_NAK         = 3'd3,
    CMD_IGNORE      = 3'd4,
    CMD_STATUS_SENT = 3'd5,
    CMD_DATA_SENT   = 3'd6,
    CMD_PAYLOAD_GOT = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_NEED_ACK     = 4'd1,
    PH_DID_ACK      = 4'd2,
    PH_DID_NAK      = 4'd3,
    PH_DID_IGNORE   = 4'd4,
    PH_HAVE_PAYLOAD = 4'd5,
    PH_GOT_PAYLOAD  = 4'd6,
    PH_NEED_STATUS  = 4'd7,
    PH_SENT_STATUS  = 4'd8,
    PH_FEED_ME      = 4'd9,
    PH_BEEN_FED     = 4'd10
  } phase_t;

  localparam logic [3:0] TY_STATUS  = 4'h1;
  localparam logic [3:0] TY_HOSTACK = 4'h2;
  localparam logic [3:0] TY_CLEAR   = 4'h3;
  localparam logic [3:0] TY_RECEIVE = 4'h4;
  localparam logic [3:0] TY_SEND    = 4'h6;
  localparam logic [3:0] TY_HOSTNAK = 4'h7;
  localparam logic [3:0] TY_READY   = 4'hd;
  localparam logic [3:0] TY_NONE    = 4'h0;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] packet_type;
  } evt_t;

  typedef struct packed {
    logic [3:0] phase_now;
    logic       violation;
  } res_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] latched_type;
  } st_t;

endpackage

@@ rtl/core/bus_transaction_phase_checker.sv @@
// Top level of the bus transaction phase checker: input register, phase state, result register.
// Uses bpc_pkg and bpc_step.
//
//   Channel | Signals                      | Direction | Beat
//   --------+------------------------------+-----------+---------------------------
//   evt     | evt_valid, evt_ready, evt    | in        | one event and packet type
//   res     | res_valid, res_ready, res    | out       | phase after event, violation
//
// An event is registered on acceptance and decoded as it enters the result register, which
// waits while a result is stalled; one event per cycle is taken while result beats are taken.
// The phase update between the input and result registers is combinational, in bpc_step.
// Reset returns the phase to idle and clears the latched type and both stage valids.
// A stalled result holds the input stage, and evt_ready drops only when both stages are full
// and the result beat is not taken in that cycle.
module bus_transaction_phase_checker
  import bpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic evt_valid,
  output logic evt_ready,
  input  evt_t evt,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic in_vld;
  evt_t in_buf;
  st_t  st;
  st_t  st_next;
  logic violation;
  logic adv;

  assign adv       = in_vld && (!res_valid || res_ready);
  assign evt_ready = !in_vld || adv;

  bpc_step u_step (
    .st        (st),
    .evt       (in_buf),
    .st_next   (st_next),
    .violation (violation)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      res_valid <= 1'b0;
      st        <= '{phase: PH_IDLE, latched_type: TY_NONE};
    end else begin
      if (evt_ready) begin
        in_vld <= evt_valid;
      end
      if (adv) begin
        st        <= st_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      in_buf <= evt;
    end
    if (adv) begin
      res.phase_now <= 4'(st_next.phase);
      res.violation <= violation;
    end
  end

endmodule

@@ rtl/core/bpc_step.sv @@
// Transition logic: next phase, latched type and violation flag for one event.
// Purely combinational; uses bpc_pkg.
module bpc_step
  import bpc_pkg::*;
(
  input  st_t        st,
  input  evt_t       evt,
  output st_t        st_next,
  output logic       violation
);

  always_comb begin
    st_next   = st;
    violation = 1'b0;
    unique case (cmd_t'(evt.cmd))
      CMD_BEGIN: begin
        st_next.latched_type = evt.packet_type;
        case (evt.packet_type)
          TY_STATUS:                st_next.phase = PH_NEED_STATUS;
          TY_SEND:                  st_next.phase = PH_HAVE_PAYLOAD;
          TY_RECEIVE, TY_READY:     st_next.phase = PH_NEED_ACK;
          TY_CLEAR:                 st_next.phase = PH_FEED_ME;
          default:                  st_next.phase = st.phase;
        endcase
      end
      CMD_FINISH: begin
        case (st.latched_type)
          TY_STATUS: begin
            violation     = !(st.phase == PH_SENT_STATUS || st.phase == PH_DID_IGNORE);
            st_next.phase = PH_IDLE;
          end
          TY_RECEIVE, TY_SEND, TY_READY: begin
            violation     = !(st.phase == PH_DID_ACK || st.phase == PH_DID_NAK ||
                              st.phase == PH_DID_IGNORE);
            st_next.phase = PH_IDLE;
          end
          TY_CLEAR: begin
            violation     = (st.phase != PH_BEEN_FED);
            st_next.phase = PH_IDLE;
          end
          TY_HOSTACK, TY_HOSTNAK: st_next.phase = PH_IDLE;
          default:                st_next.phase = st.phase;
        endcase
      end
      CMD_ACK: begin
        violation     = !(st.phase == PH_NEED_ACK || st.phase == PH_GOT_PAYLOAD);
        st_next.phase = PH_DID_ACK;
      end
      CMD_NAK: begin
        violation     = !(st.phase == PH_NEED_ACK || st.phase == PH_GOT_PAYLOAD);
        st_next.phase = PH_DID_NAK;
      end
      CMD_IGNORE: begin
        violation     = !(st.phase == PH_NEED_ACK || st.phase == PH_NEED_STATUS);
        st_next.phase = PH_DID_IGNORE;
      end
      CMD_STATUS_SENT: begin
        violation     = (st.phase != PH_NEED_STATUS);
        st_next.phase = PH_SENT_STATUS;
      end
      CMD_DATA_SENT: begin
        violation     = !(st.phase == PH_FEED_ME || st.phase == PH_NEED_STATUS);
        st_next.phase = (st.phase == PH_FEED_ME) ? PH_BEEN_FED : st.phase;
      end
      CMD_PAYLOAD_GOT: begin
        violation     = (st.phase != PH_HAVE_PAYLOAD);
        st_next.phase = PH_GOT_PAYLOAD;
      end
    endcase
  end

endmodule
